@@ rtl/core/touch_pressure_pen_tracker_top_defines.svh @@
// assertion macros used by the checker file
`ifndef TOUCH_PRESSURE_PEN_TRACKER_TOP_DEFINES_SVH
`define TOUCH_PRESSURE_PEN_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define TPPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tppt check failed");

// next-cycle implication, quiet while reset is held
`define TPPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tppt check failed");

`endif

@@ rtl/core/tppt_pkg.sv @@
package tppt_pkg;

  localparam int WORD_W    = 16;
  localparam int POS_W     = 13;
  localparam int PRESS_W   = 12;
  localparam int REG_W     = 10;
  localparam int EV_W      = 2;
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLATE_OHMS       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_CEILING = 1'd1;

  localparam logic [REG_W-1:0] PLATE_OHMS_RESET       = 10'd100;
  localparam logic [REG_W-1:0] PRESSURE_CEILING_RESET = 10'd300;

  // result event codes
  localparam logic [EV_W-1:0] EV_REQUEST = 2'd0;
  localparam logic [EV_W-1:0] EV_REPORT  = 2'd1;
  localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_REQUEST,
    OP_RELEASE,
    OP_SAMPLE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z1;
    logic [POS_W-1:0] z2;
  } cmd_t;

endpackage

@@ rtl/core/touch_pressure_pen_tracker_top.sv @@
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready   | tuser kind, tdata pen level and y, x, z1, z2 words
// out_    | out | out_tvalid / out_tready | tuser event, tdata x, y, pressure, touching
// cfg_    | in  | cfg_we                  | cfg_index register, cfg_wdata value
//
// a tick result passes through the command queue and the output register; a sample goes through
// pop, load, the 23-step restoring divider for z2*ohms/z1, multiply, scale and finish
// the back end takes one sample at a time; a two-entry command queue lets the
// front keep accepting ticks while a sample is in the divider, and stalls input when full
// the output register holds a result until taken; the back end stalls only on its next result
// synchronous active-low reset clears pen flags, queue and output valid
module touch_pressure_pen_tracker_top
  import tppt_pkg::*;
#(
  parameter int FULL_SCALE_SHIFT = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tuser,   // [0] kind
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] pen_level, [16:1] y_word, [32:17] x_word,
                                             // [48:33] z1_word, [64:49] z2_word, rest zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [EV_W-1:0]        out_tuser,  // [1:0] event_res
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [12:0] pos_x, [25:13] pos_y,
                                             // [37:26] touch_pressure, [38] touching, [39] zero
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_wdata
);

  logic [REG_W-1:0] plate_ohms_r;
  logic [REG_W-1:0] pressure_ceiling_r;
  logic             q_full;
  logic             q_valid;
  logic             push;
  logic             pop;
  cmd_t             push_cmd;
  cmd_t             q_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plate_ohms_r       <= PLATE_OHMS_RESET;
      pressure_ceiling_r <= PRESSURE_CEILING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLATE_OHMS:       plate_ohms_r       <= cfg_wdata;
        CFG_PRESSURE_CEILING: pressure_ceiling_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // pen tracking and classification
  tppt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // command queue
  tppt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_cmd    (q_cmd)
  );

  // pressure computation and result register
  tppt_back #(
    .FULL_SCALE_SHIFT (FULL_SCALE_SHIFT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .pop              (pop),
    .plate_ohms       (plate_ohms_r),
    .pressure_ceiling (pressure_ceiling_r),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tuser        (out_tuser),
    .out_tdata        (out_tdata)
  );

endmodule

@@ rtl/core/tppt_front.sv @@
module tppt_front
  import tppt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  q_full,
  output logic                  push,
  output cmd_t                  push_cmd
);

  logic touched_r, touched_nxt;
  logic pending_r, pending_nxt;
  logic accept;
  logic pen_level;
  logic [WORD_W-1:0] y_word, x_word, z1_word, z2_word;

  // unpack the request
  assign pen_level = in_tdata[0];
  assign y_word    = in_tdata[16:1];
  assign x_word    = in_tdata[32:17];
  assign z1_word   = in_tdata[48:33];
  assign z2_word   = in_tdata[64:49];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // pen tracking and classification
  always_comb begin
    touched_nxt    = touched_r;
    pending_nxt    = pending_r;
    push           = 1'b0;
    push_cmd.op    = OP_SAMPLE;
    push_cmd.x     = x_word[WORD_W-1:3];
    push_cmd.y     = y_word[WORD_W-1:3];
    push_cmd.z1    = z1_word[WORD_W-1:3];
    push_cmd.z2    = z2_word[WORD_W-1:3];
    if (accept) begin
      if (!in_tuser) begin
        if (!pen_level && !pending_r) begin
          touched_nxt = 1'b1;
          pending_nxt = 1'b1;
          push        = 1'b1;
          push_cmd.op = OP_REQUEST;
        end else if (pen_level && touched_r) begin
          touched_nxt = 1'b0;
          pending_nxt = 1'b0;
          push        = 1'b1;
          push_cmd.op = OP_RELEASE;
        end
      end else begin
        pending_nxt = 1'b0;
        // a sample with a zero pressure reading is dropped here
        push = (push_cmd.z1 != '0) && (push_cmd.z2 != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touched_r <= 1'b0;
      pending_r <= 1'b0;
    end else begin
      touched_r <= touched_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

@@ rtl/core/tppt_queue.sv @@
module tppt_queue
  import tppt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output cmd_t q_cmd
);

  cmd_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_cmd   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/tppt_back.sv @@
module tppt_back
  import tppt_pkg::*;
#(
  parameter int FULL_SCALE_SHIFT = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  cmd_t                   q_cmd,
  output logic                   pop,
  input  logic [REG_W-1:0]       plate_ohms,
  input  logic [REG_W-1:0]       pressure_ceiling,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [EV_W-1:0]        out_tuser,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int NUM_W  = POS_W + REG_W;          // z2 * ohms
  localparam int DIFF_W = NUM_W + 1;              // signed q - ohms
  localparam int XS_W   = POS_W + 1;              // signed x
  localparam int PROD_W = DIFF_W + XS_W;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam logic signed [PROD_W-1:0] ROUND_BIAS =
    PROD_W'((64'd1 << FULL_SCALE_SHIFT) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_SCALE,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [POS_W-1:0]         x_r, x_nxt;
  logic [POS_W-1:0]         y_r, y_nxt;
  logic [POS_W-1:0]         z1_r, z1_nxt;
  logic [POS_W-1:0]         z2_r, z2_nxt;
  logic [NUM_W-1:0]         quo_r, quo_nxt;
  logic [POS_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PROD_W-1:0] p_r, p_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [EV_W-1:0]          out_event_r, out_event_nxt;
  logic [POS_W-1:0]         out_x_r, out_x_nxt;
  logic [POS_W-1:0]         out_y_r, out_y_nxt;
  logic [PRESS_W-1:0]       out_press_r, out_press_nxt;
  logic                     out_touch_r, out_touch_nxt;

  logic                     slot_free;
  logic [POS_W:0]           rem_sh;
  logic [POS_W:0]           rem_diff;
  logic signed [DIFF_W-1:0] diff;
  logic signed [XS_W-1:0]   xs;
  logic signed [PROD_W-1:0] bias;
  logic signed [PROD_W-1:0] c_ext;
  logic signed [PROD_W-1:0] p_clamp;
  logic signed [PROD_W-1:0] rep;

  assign slot_free = !out_valid_r || out_tready;

  // divider step, one quotient bit per cycle
  assign rem_sh   = {rem_r, quo_r[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, z1_r};

  // q - ohms and the signed x operand
  assign diff = $signed({1'b0, quo_r}) - $signed({{(DIFF_W-REG_W){1'b0}}, plate_ohms});
  assign xs   = $signed({1'b0, x_r});

  // bias for negative products so the shift truncates toward zero
  assign bias = prod_r[PROD_W-1] ? ROUND_BIAS : '0;

  // clamp against the ceiling and take the reported value
  assign c_ext   = $signed(PROD_W'(pressure_ceiling));
  assign p_clamp = (p_r > c_ext) ? c_ext - 1 : p_r;
  assign rep     = c_ext - p_clamp;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z1_nxt        = z1_r;
    z2_nxt        = z2_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r;
    out_event_nxt = out_event_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_press_nxt = out_press_r;
    out_touch_nxt = out_touch_r;
    pop           = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == OP_SAMPLE) begin
            pop       = 1'b1;
            x_nxt     = q_cmd.x;
            y_nxt     = q_cmd.y;
            z1_nxt    = q_cmd.z1;
            z2_nxt    = q_cmd.z2;
            state_nxt = S_LOAD;
          end else if (slot_free) begin
            pop           = 1'b1;
            out_valid_nxt = 1'b1;
            out_event_nxt = (q_cmd.op == OP_REQUEST) ? EV_REQUEST : EV_RELEASE;
            out_x_nxt     = '0;
            out_y_nxt     = '0;
            out_press_nxt = '0;
            out_touch_nxt = (q_cmd.op == OP_REQUEST);
          end
        end
      end
      S_LOAD: begin
        quo_nxt   = {{REG_W{1'b0}}, z2_r} * {{POS_W{1'b0}}, plate_ohms};
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!rem_diff[POS_W]) begin
          rem_nxt = rem_diff[POS_W-1:0];
          quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[POS_W-1:0];
          quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W-1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = diff * xs;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        // truncate toward zero: bias negative values before the shift
        p_nxt     = (prod_r + bias) >>> FULL_SCALE_SHIFT;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_event_nxt = EV_REPORT;
          out_x_nxt     = x_r;
          out_y_nxt     = y_r;
          out_press_nxt = rep[PRESS_W-1:0];
          out_touch_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z1_r        <= z1_nxt;
    z2_r        <= z2_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    prod_r      <= prod_nxt;
    p_r         <= p_nxt;
    out_event_r <= out_event_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_press_r <= out_press_nxt;
    out_touch_r <= out_touch_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_event_r;
  assign out_tdata  = {1'b0, out_touch_r, out_press_r, out_y_r, out_x_r};

endmodule

@@ rtl/core/tppt_checker.sv @@
`include "touch_pressure_pen_tracker_top_defines.svh"

module tppt_checker
  import tppt_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [EV_W-1:0]        out_tuser,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds its event and payload
  `TPPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // release carries no position, no pressure and touching low
  `TPPT_ASSERT_NOW(a_release_clear, clk, rst_n, out_tvalid && (out_tuser == EV_RELEASE), out_tdata == '0)

  // request carries no position or pressure, touching high
  `TPPT_ASSERT_NOW(a_request_form, clk, rst_n, out_tvalid && (out_tuser == EV_REQUEST), out_tdata[37:0] == '0 && out_tdata[38])

  // reports always have touching set and the pad bit clear
  `TPPT_ASSERT_NOW(a_report_touch, clk, rst_n, out_tvalid && (out_tuser == EV_REPORT), out_tdata[38] && !out_tdata[39])

endmodule

bind touch_pressure_pen_tracker_top tppt_checker u_tppt_checker (.*);
